FILE: hw/rtl/dump_stream_parser_crc64_unit_macros.svh
// Assertion macros for the dump stream parser checker.
// Included by the checker file only; holds no logic.
`ifndef DUMP_STREAM_PARSER_CRC64_UNIT_MACROS_SVH
`define DUMP_STREAM_PARSER_CRC64_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define DSPC_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define DSPC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define DSPC_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/dspc_pkg.sv
// Shared types and constants for the dump stream parser with CRC-64 check.
// No dependencies; imported by every module of the block.
package dspc_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned WORD_W     = 32;
   localparam int unsigned CRC_W      = 64;
   localparam int unsigned KIND_W     = 3;
   localparam int unsigned STATUS_W   = 3;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned RSP_BITS   = BYTE_W + STATUS_W + 2 * WORD_W;
   localparam int unsigned RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [CRC_W-1:0] CRC_POLY = 64'h42F0_E1EB_A9EA_3693;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_DB   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_VERSION = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_VERSION = 2'd2;

   localparam logic [WORD_W-1:0] RST_TARGET_DB   = 32'd0;
   localparam logic [WORD_W-1:0] RST_MIN_VERSION = 32'd1;
   localparam logic [WORD_W-1:0] RST_MAX_VERSION = 32'd12;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_KEY_BYTE    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_VALUE_BYTE  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_EMPTY_KEY   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_EMPTY_VALUE = 3'd3;
   localparam logic [KIND_W-1:0] KIND_STATUS      = 3'd4;

   // Load status codes
   localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_MAGIC    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_VERSION  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_CORRUPTED    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_CRC_MISMATCH = 3'd4;

   // Opcodes and length prefix tags
   localparam logic [BYTE_W-1:0] OP_EOF       = 8'hFF;
   localparam logic [BYTE_W-1:0] OP_SELECT_DB = 8'hFE;
   localparam logic [BYTE_W-1:0] OP_PAIR      = 8'h00;
   localparam logic [1:0] LEN_TAG_6BIT  = 2'b00;
   localparam logic [1:0] LEN_TAG_14BIT = 2'b01;
   localparam logic [1:0] LEN_TAG_32BIT = 2'b10;

   localparam logic [3:0] MAGIC_LEN      = 4'd5;
   localparam logic [3:0] HEADER_LEN     = 4'd9;
   localparam logic [3:0] TAIL_LEN       = 4'd8;

   typedef enum logic [3:0] {
      PH_MAGIC    = 4'd0,
      PH_VERSION  = 4'd1,
      PH_OPCODE   = 4'd2,
      PH_LEN_DB   = 4'd3,
      PH_LEN_SKIP = 4'd4,
      PH_LEN_KEY  = 4'd5,
      PH_LEN_VAL  = 4'd6,
      PH_KEY      = 4'd7,
      PH_VAL      = 4'd8,
      PH_DONE     = 4'd9,
      PH_FAILED   = 4'd10
   } phase_type;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [BYTE_W-1:0]   payload;
      logic                string_end;
      logic [STATUS_W-1:0] status;
      logic [WORD_W-1:0]   format_version;
      logic [WORD_W-1:0]   pairs_loaded;
   } result_type;

   // Up to two results per accepted byte, in delivery order
   typedef struct packed {
      logic       valid0;
      logic       valid1;
      result_type item0;
      result_type item1;
   } res_push_type;

   // Checksum view after the current byte is taken in
   typedef struct packed {
      logic tail_full;
      logic crc_match;
   } crc_status_type;

   function automatic logic [BYTE_W-1:0] magic_byte(input logic [2:0] idx);
      logic [BYTE_W-1:0] b;
      case (idx)
         3'd0:    b = 8'h52;
         3'd1:    b = 8'h45;
         3'd2:    b = 8'h44;
         3'd3:    b = 8'h49;
         3'd4:    b = 8'h53;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

FILE: hw/rtl/dspc_crc.sv
// CRC-64 engine and eight-byte tail delay line of the dump stream parser.
// Depends on dspc_pkg.
module dspc_crc (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic                        fin,
   input  logic [dspc_pkg::BYTE_W-1:0] data_byte,
   output dspc_pkg::crc_status_type    crc_view
);
   import dspc_pkg::*;

   logic [BYTE_W-1:0] tail_ff [TAIL_LEN];
   logic [BYTE_W-1:0] tail_in [TAIL_LEN];
   logic [3:0]        fill_ff, fill_in;
   logic [CRC_W-1:0]  crc_ff, crc_in;
   logic [CRC_W-1:0]  stored;

   // One byte through the right-shifting CRC, eight bit steps unrolled
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c,
                                                 input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] r;
      r = c ^ {{(CRC_W-BYTE_W){1'b0}}, b};
      for (int i = 0; i < BYTE_W; i++) begin
         r = r[0] ? ({1'b0, r[CRC_W-1:1]} ^ CRC_POLY) : {1'b0, r[CRC_W-1:1]};
      end
      return r;
   endfunction

   // Feed the oldest held byte once the line is full, otherwise fill it
   always_comb begin
      tail_in = tail_ff;
      fill_in = fill_ff;
      crc_in  = crc_ff;
      if (fill_ff >= TAIL_LEN) begin
         crc_in = crc_byte(crc_ff, tail_ff[0]);
         for (int i = 0; i < TAIL_LEN - 1; i++) begin
            tail_in[i] = tail_ff[i+1];
         end
         tail_in[TAIL_LEN-1] = data_byte;
      end else begin
         tail_in[fill_ff[2:0]] = data_byte;
         fill_in = fill_ff + 4'd1;
      end
   end

   // Held bytes read big-endian, first byte most significant
   always_comb begin
      stored = '0;
      for (int i = 0; i < TAIL_LEN; i++) begin
         stored = {stored[CRC_W-BYTE_W-1:0], tail_in[i]};
      end
      crc_view.tail_full = (fill_in >= TAIL_LEN);
      crc_view.crc_match = (stored == crc_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         crc_ff  <= '0;
      end else if (step) begin
         if (fin) begin
            fill_ff <= '0;
            crc_ff  <= '0;
         end else begin
            fill_ff <= fill_in;
            crc_ff  <= crc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         tail_ff <= tail_in;
      end
   end

endmodule

FILE: hw/rtl/dspc_parser.sv
// Header check, opcode and length parser of the dump stream parser.
// Depends on dspc_pkg; takes the checksum view from dspc_crc.
module dspc_parser (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic                        fin,
   input  logic [dspc_pkg::BYTE_W-1:0] data_byte,
   input  logic [dspc_pkg::WORD_W-1:0] target_database,
   input  logic [dspc_pkg::WORD_W-1:0] min_version,
   input  logic [dspc_pkg::WORD_W-1:0] max_version,
   input  dspc_pkg::crc_status_type    crc_view,
   output dspc_pkg::res_push_type      push
);
   import dspc_pkg::*;

   phase_type           phase_ff, phase_in;
   logic [3:0]          hdr_ff, hdr_in;
   logic [WORD_W-1:0]   ver_ff, ver_in;
   logic [WORD_W-1:0]   len_acc_ff, len_acc_in;
   logic [2:0]          len_left_ff, len_left_in;
   logic [WORD_W-1:0]   str_left_ff, str_left_in;
   logic [1:0]          skip_ff, skip_in;
   logic [STATUS_W-1:0] err_ff, err_in;
   logic [WORD_W-1:0]   pairs_ff, pairs_in;

   logic [WORD_W-1:0]   len_acc_dec;
   logic [2:0]          len_left_dec;
   logic                len_done;
   logic [WORD_W-1:0]   len_val;
   logic                str_last;
   logic [WORD_W-1:0]   pairs_inc;

   assign str_last  = (str_left_ff == {{(WORD_W-1){1'b0}}, 1'b1});
   assign pairs_inc = (&pairs_ff) ? pairs_ff : pairs_ff + 1'b1;

   // Length prefix decode
   always_comb begin
      len_acc_dec  = len_acc_ff;
      len_left_dec = len_left_ff;
      len_done     = 1'b0;
      len_val      = '0;
      if (len_left_ff == 3'd0) begin
         case (data_byte[7:6])
            LEN_TAG_6BIT: begin
               len_done = 1'b1;
               len_val  = {{(WORD_W-6){1'b0}}, data_byte[5:0]};
            end
            LEN_TAG_14BIT: begin
               len_acc_dec  = {{(WORD_W-6){1'b0}}, data_byte[5:0]};
               len_left_dec = 3'd1;
            end
            LEN_TAG_32BIT: begin
               len_acc_dec  = '0;
               len_left_dec = 3'd4;
            end
            default: begin
               len_done = 1'b1;
            end
         endcase
      end else begin
         len_acc_dec  = {len_acc_ff[WORD_W-BYTE_W-1:0], data_byte};
         len_left_dec = len_left_ff - 3'd1;
         if (len_left_dec == 3'd0) begin
            len_done = 1'b1;
            len_val  = len_acc_dec;
         end
      end
   end

   // Next state
   always_comb begin
      phase_in    = phase_ff;
      hdr_in      = hdr_ff;
      ver_in      = ver_ff;
      len_acc_in  = len_acc_ff;
      len_left_in = len_left_ff;
      str_left_in = str_left_ff;
      skip_in     = skip_ff;
      err_in      = err_ff;
      pairs_in    = pairs_ff;
      case (phase_ff)
         PH_MAGIC: begin
            if (data_byte == magic_byte(hdr_ff[2:0])) begin
               hdr_in = hdr_ff + 4'd1;
               if (hdr_in == MAGIC_LEN) begin
                  phase_in = PH_VERSION;
               end
            end else begin
               err_in   = ST_BAD_MAGIC;
               phase_in = PH_FAILED;
            end
         end
         PH_VERSION: begin
            ver_in = {ver_ff[WORD_W-BYTE_W-1:0], data_byte};
            hdr_in = hdr_ff + 4'd1;
            if (hdr_in >= HEADER_LEN) begin
               if (ver_in >= min_version && ver_in <= max_version) begin
                  phase_in = PH_OPCODE;
               end else begin
                  err_in   = ST_BAD_VERSION;
                  phase_in = PH_FAILED;
               end
            end
         end
         PH_OPCODE: begin
            len_left_in = 3'd0;
            case (data_byte)
               OP_EOF:       phase_in = PH_DONE;
               OP_SELECT_DB: phase_in = PH_LEN_DB;
               OP_PAIR:      phase_in = PH_LEN_KEY;
               default: begin
                  err_in   = ST_CORRUPTED;
                  phase_in = PH_FAILED;
               end
            endcase
         end
         PH_LEN_DB, PH_LEN_SKIP, PH_LEN_KEY, PH_LEN_VAL: begin
            len_acc_in  = len_acc_dec;
            len_left_in = len_left_dec;
            if (len_done) begin
               case (phase_ff)
                  PH_LEN_DB: begin
                     if (len_val == target_database) begin
                        phase_in = PH_LEN_SKIP;
                        skip_in  = 2'd2;
                     end else begin
                        phase_in = PH_OPCODE;
                     end
                  end
                  PH_LEN_SKIP: begin
                     skip_in = skip_ff - 2'd1;
                     if (skip_in == 2'd0) begin
                        phase_in = PH_OPCODE;
                     end
                  end
                  PH_LEN_KEY: begin
                     if (len_val == '0) begin
                        phase_in = PH_LEN_VAL;
                     end else begin
                        str_left_in = len_val;
                        phase_in    = PH_KEY;
                     end
                  end
                  default: begin
                     if (len_val == '0) begin
                        pairs_in = pairs_inc;
                        phase_in = PH_OPCODE;
                     end else begin
                        str_left_in = len_val;
                        phase_in    = PH_VAL;
                     end
                  end
               endcase
            end
         end
         PH_KEY, PH_VAL: begin
            str_left_in = str_left_ff - 1'b1;
            if (str_last) begin
               len_left_in = 3'd0;
               if (phase_ff == PH_VAL) begin
                  pairs_in = pairs_inc;
                  phase_in = PH_OPCODE;
               end else begin
                  phase_in = PH_LEN_VAL;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Result items
   always_comb begin
      result_type parse_item;
      result_type status_item;
      logic       parse_valid;
      parse_item  = '0;
      status_item = '0;
      parse_valid = 1'b0;
      case (phase_ff)
         PH_KEY, PH_VAL: begin
            parse_valid           = 1'b1;
            parse_item.kind       = (phase_ff == PH_VAL) ? KIND_VALUE_BYTE : KIND_KEY_BYTE;
            parse_item.payload    = data_byte;
            parse_item.string_end = str_last;
         end
         PH_LEN_KEY: begin
            parse_valid     = len_done && (len_val == '0);
            parse_item.kind = KIND_EMPTY_KEY;
         end
         PH_LEN_VAL: begin
            parse_valid     = len_done && (len_val == '0);
            parse_item.kind = KIND_EMPTY_VALUE;
         end
         default: begin
         end
      endcase

      status_item.kind         = KIND_STATUS;
      status_item.pairs_loaded = pairs_in;
      if (!(phase_in == PH_MAGIC || phase_in == PH_VERSION || err_in == ST_BAD_MAGIC)) begin
         status_item.format_version = ver_in;
      end
      if (err_in != ST_OK) begin
         status_item.status = err_in;
      end else if (phase_in == PH_MAGIC) begin
         status_item.status = ST_BAD_MAGIC;
      end else if (phase_in == PH_VERSION) begin
         status_item.status = ST_BAD_VERSION;
      end else if (phase_in == PH_LEN_KEY || phase_in == PH_LEN_VAL ||
                   phase_in == PH_KEY || phase_in == PH_VAL) begin
         status_item.status = ST_CORRUPTED;
      end else if (!crc_view.tail_full || !crc_view.crc_match) begin
         status_item.status = ST_CRC_MISMATCH;
      end else begin
         status_item.status = ST_OK;
      end

      // Compact: a parse result always goes first
      if (parse_valid) begin
         push.valid0 = step;
         push.item0  = parse_item;
         push.valid1 = step && fin;
         push.item1  = status_item;
      end else begin
         push.valid0 = step && fin;
         push.item0  = status_item;
         push.valid1 = 1'b0;
         push.item1  = status_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && fin)) begin
         phase_ff    <= PH_MAGIC;
         hdr_ff      <= '0;
         ver_ff      <= '0;
         len_acc_ff  <= '0;
         len_left_ff <= '0;
         str_left_ff <= '0;
         skip_ff     <= '0;
         err_ff      <= ST_OK;
         pairs_ff    <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         hdr_ff      <= hdr_in;
         ver_ff      <= ver_in;
         len_acc_ff  <= len_acc_in;
         len_left_ff <= len_left_in;
         str_left_ff <= str_left_in;
         skip_ff     <= skip_in;
         err_ff      <= err_in;
         pairs_ff    <= pairs_in;
      end
   end

endmodule

FILE: hw/rtl/dspc_outq.sv
// Result queue of the dump stream parser: takes up to two items a cycle,
// hands out one. Depends on dspc_pkg.
module dspc_outq #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dspc_pkg::res_push_type push,
   output dspc_pkg::result_type   head,
   output logic                   head_valid,
   input  logic                   head_ready,
   output logic                   room
);
   import dspc_pkg::*;

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   result_type       mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]       push_n;
   logic             pop;

   assign push_n     = {1'b0, push.valid0} + {1'b0, push.valid1};
   assign head_valid = (cnt_ff != '0);
   assign head       = mem[rd_ptr_ff];
   assign pop        = head_valid && head_ready;
   assign room       = (cnt_ff <= CNT_W'(DEPTH - 2));

   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push_n);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign cnt_in    = cnt_ff + CNT_W'(push_n) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid0) begin
         mem[wr_ptr_ff] <= push.item0;
      end
      if (push.valid1) begin
         mem[wr_ptr_ff + PTR_W'(1)] <= push.item1;
      end
   end

endmodule

FILE: hw/rtl/dump_stream_parser_crc64_unit.sv
// Top level of the dump stream parser with CRC-64 check.
// Depends on dspc_pkg, dspc_crc, dspc_parser and dspc_outq.
//
// Usage:
//   req_*  carries the dump file one byte per transaction; req_tlast marks
//          the final byte of a file.
//   rsp_*  carries result items: key and value bytes (rsp_tlast on the last
//          byte of a string), empty key / empty value markers, and one load
//          status item after the final byte of each file.
//   csr_*  writes target_database (0), min_version (1) and max_version (2);
//          write only while no file is in flight.
//   A result enters the result queue as its byte is taken; with the queue empty
//   it shows on rsp_tvalid the cycle after. Throughput: one byte per cycle while
//   the result queue has room; the parser and the 8-bit CRC update sit between
//   the state registers and the result queue in one pass. The final byte may
//   give two items, handed out in turn. A stalled receiver fills the result
//   queue; req_tready drops while fewer than two free entries remain and comes back as items drain.
//   Reset (synchronous, active high) empties the queue, returns the parser to
//   the magic check and loads register defaults 0, 1 and 12. After each
//   status item the parser returns to that same state for the next file.
module dump_stream_parser_crc64_unit #(
   parameter int unsigned RSP_QUEUE_DEPTH = 4
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // input channel
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [dspc_pkg::BYTE_W-1:0]            req_tdata,   // [7:0] data_byte
   input  logic                                   req_tlast,   // final_byte
   // result channel
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [dspc_pkg::RSP_TDATA_W-1:0]       rsp_tdata,   // payload, status,
                                                               // format_version,
                                                               // pairs_loaded, zero pad
   output logic [dspc_pkg::KIND_W-1:0]            rsp_tuser,   // kind
   output logic                                   rsp_tlast,   // string_end
   // configuration port
   input  logic                                   csr_wr_en,
   input  logic [dspc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [dspc_pkg::WORD_W-1:0]            csr_wdata
);
   import dspc_pkg::*;

   logic [WORD_W-1:0] target_db_ff;
   logic [WORD_W-1:0] min_ver_ff;
   logic [WORD_W-1:0] max_ver_ff;
   logic              step;
   logic              room;
   crc_status_type    crc_view;
   res_push_type      push;
   result_type        head;

   assign req_tready = room;
   assign step       = req_tvalid && req_tready;

   // Configuration registers; an index past the list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         target_db_ff <= RST_TARGET_DB;
         min_ver_ff   <= RST_MIN_VERSION;
         max_ver_ff   <= RST_MAX_VERSION;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_TARGET_DB:   target_db_ff <= csr_wdata;
            CSR_MIN_VERSION: min_ver_ff   <= csr_wdata;
            CSR_MAX_VERSION: max_ver_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Checksum over all bytes but the last eight, held in the tail line
   dspc_crc u_crc (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .fin       (req_tlast),
      .data_byte (req_tdata),
      .crc_view  (crc_view)
   );

   // Header, opcode and length parsing; builds up to two results per byte
   dspc_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .fin             (req_tlast),
      .data_byte       (req_tdata),
      .target_database (target_db_ff),
      .min_version     (min_ver_ff),
      .max_version     (max_ver_ff),
      .crc_view        (crc_view),
      .push            (push)
   );

   // Result queue decouples the parser from a stalling receiver
   dspc_outq #(
      .DEPTH (RSP_QUEUE_DEPTH)
   ) u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .head       (head),
      .head_valid (rsp_tvalid),
      .head_ready (rsp_tready),
      .room       (room)
   );

   assign rsp_tdata = {{(RSP_TDATA_W - RSP_BITS){1'b0}}, head.pairs_loaded,
                       head.format_version, head.status, head.payload};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.string_end;

endmodule

FILE: hw/rtl/dspc_checker.sv
// Port-level assertions for the dump stream parser, bound to the top level.
// Depends on dspc_pkg and dump_stream_parser_crc64_unit_macros.svh.
`include "dump_stream_parser_crc64_unit_macros.svh"

module dspc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             req_tlast,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [dspc_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [dspc_pkg::KIND_W-1:0]      rsp_tuser,
   input logic                             rsp_tlast
);
   import dspc_pkg::*;

   // Hold a stalled result
   `DSPC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "stalled result changed")

   // Only status items carry status, version and pair count
   `DSPC_ASSERT_IMPLY(a_data_clean, clock, reset, rsp_tvalid && rsp_tuser != KIND_STATUS, rsp_tdata[RSP_TDATA_W-1:BYTE_W] == '0, "non-status item carries status fields")

   // String end only on key or value bytes
   `DSPC_ASSERT_IMPLY(a_last_kind, clock, reset, rsp_tvalid && rsp_tlast, rsp_tuser == KIND_KEY_BYTE || rsp_tuser == KIND_VALUE_BYTE, "string end on a non-byte item")

   // A final byte always leaves a result pending in the next cycle
   `DSPC_ASSERT_NEXT(a_status_follows, clock, reset, req_tvalid && req_tready && req_tlast, rsp_tvalid, "no result after final byte")

   // Reset empties the result queue
   `DSPC_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid, "result pending after reset")

endmodule

bind dump_stream_parser_crc64_unit dspc_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
